/* hdl/assert_macros.svh */
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, kept on during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/mau_pkg.sv */
// Types and constants of the modular arithmetic unit.
package mau_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_INV = 3'd4;
    localparam logic [2:0] OP_POW = 3'd5;
    localparam logic [2:0] OP_NEG = 3'd6;
    localparam logic [2:0] OP_RED = 3'd7;

    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_DISP,
        S_RED_SV,
        S_MUL,
        S_MUL_RET,
        S_EU_CHK,
        S_EU_DIV,
        S_PW_CHK,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MR_OUT,
        MR_EU,
        MR_PACC,
        MR_PBASE
    } t_mret;

endpackage

/* hdl/modular_arithmetic_unit.sv */
// Modular arithmetic unit: bit-serial add, sub, mul, div, inverse, pow, negate, reduce.
//
// Input channel i_s_axis_*: tuser carries the operation code, tdata the operands,
// exponent and signed value. Output channel o_m_axis_*: tdata the reduced result,
// tuser the operand equality flag. One result per transfer, in order.
// The modulus is written through i_cfg_wr_en / i_cfg_wr_data; the user must write it
// only while idle, as the block does not enforce this. One item at a time.
// Both operands are first reduced, one bit per cycle. A single shift-and-add
// multiplier serves mul, div, inverse and pow; a restoring divider gives the quotients.
// After reduction add, sub and neg are computed directly; mul takes one product.
// reduce: the 64-bit signed value's magnitude is reduced, then negated if negative.
// inverse: extended Euclid, a division then a product per step, up to about 45 steps.
// div: the inverse of b, then its product with a. pow: square-and-multiply, 63 bits.
// The result sits in an output register; a stalled receiver holds it there
// while the next item is accepted and worked on, which then waits to leave.
// Reset (synchronous, active low) empties the output register, returns to idle
// and loads the modulus with 1000000007.
module modular_arithmetic_unit #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_wr_en,
    input  logic [VALUE_WIDTH-1:0]                        i_cfg_wr_data,
    input  logic                                          i_s_axis_tvalid,
    output logic                                          o_s_axis_tready,
    // operand_a, operand_b, exponent[62:0], signed_value[63:0], zero fill
    input  logic [((2*VALUE_WIDTH+127+7)/8)*8-1:0]        i_s_axis_tdata,
    // operation[2:0]
    input  logic [2:0]                                    i_s_axis_tuser,
    output logic                                          o_m_axis_tvalid,
    input  logic                                          i_m_axis_tready,
    // result, zero fill
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]              o_m_axis_tdata,
    // is_equal
    output logic [0:0]                                    o_m_axis_tuser
);
    import mau_pkg::*;

    `include "assert_macros.svh"

    localparam int W  = VALUE_WIDTH;
    localparam int OW = ((VALUE_WIDTH+7)/8)*8;

    t_state         r_state, n_state;
    t_mret          r_mret, n_mret;
    logic [W-1:0]   r_m;
    logic [2:0]     r_op, n_op;
    logic           r_eq, n_eq;
    logic [62:0]    r_exp, n_exp;
    logic [63:0]    r_sv, n_sv;
    logic [63:0]    r_sh, n_sh;
    logic [6:0]     r_cnt, n_cnt;
    logic [W-1:0]   r_rem, n_rem;
    logic [W-1:0]   r_a, n_a;
    logic [W-1:0]   r_b, n_b;
    logic [W-1:0]   r_mx, n_mx;
    logic [W-1:0]   r_my, n_my;
    logic [W-1:0]   r_macc, n_macc;
    logic [W-1:0]   r_ea, n_ea;
    logic [W-1:0]   r_eb, n_eb;
    logic [W-1:0]   r_u, n_u;
    logic [W-1:0]   r_v, n_v;
    logic [W-1:0]   r_acc, n_acc;
    logic [W-1:0]   r_base, n_base;
    logic [W-1:0]   r_res, n_res;
    logic           r_ovalid, n_ovalid;
    logic [W-1:0]   r_ores, n_ores;
    logic           r_oeq, n_oeq;

    logic [W:0]     mm;
    logic [W:0]     red_t, red_n;
    logic [W-1:0]   red_q;
    logic [W:0]     mul_d, mul_d1, mul_s, mul_s1;
    logic [W-1:0]   mul_q;
    logic [W:0]     div_t, div_r;
    logic           div_ge;
    logic [W-1:0]   div_q;
    logic           s_accept;

    function automatic logic [W-1:0] add_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] sub_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
        logic [W:0] s;
        if (x >= y)
            s = {1'b0, x} - {1'b0, y};
        else
            s = {1'b0, x} + ({1'b0, m} - {1'b0, y});
        return s[W-1:0];
    endfunction

    assign mm = {1'b0, r_m};

    assign red_t = {r_rem, r_sh[63]};
    assign red_n = (red_t >= mm) ? red_t - mm : red_t;
    assign red_q = red_n[W-1:0];

    assign mul_d  = {r_macc, 1'b0};
    assign mul_d1 = (mul_d >= mm) ? mul_d - mm : mul_d;
    assign mul_s  = {1'b0, mul_d1[W-1:0]} + {1'b0, r_mx};
    assign mul_s1 = r_my[W-1] ? ((mul_s >= mm) ? mul_s - mm : mul_s) : mul_d1;
    assign mul_q  = mul_s1[W-1:0];

    assign div_t  = {r_rem, r_ea[W-1]};
    assign div_ge = div_t >= {1'b0, r_eb};
    assign div_r  = div_ge ? div_t - {1'b0, r_eb} : div_t;
    assign div_q  = {r_ea[W-2:0], div_ge};

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = OW'(r_ores);
    assign o_m_axis_tuser  = r_oeq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_m      <= MODULUS_RESET[W-1:0];
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_wr_en)
                r_m <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mret <= n_mret;
        r_op   <= n_op;
        r_eq   <= n_eq;
        r_exp  <= n_exp;
        r_sv   <= n_sv;
        r_sh   <= n_sh;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_a    <= n_a;
        r_b    <= n_b;
        r_mx   <= n_mx;
        r_my   <= n_my;
        r_macc <= n_macc;
        r_ea   <= n_ea;
        r_eb   <= n_eb;
        r_u    <= n_u;
        r_v    <= n_v;
        r_acc  <= n_acc;
        r_base <= n_base;
        r_res  <= n_res;
        r_ores <= n_ores;
        r_oeq  <= n_oeq;
    end

    always_comb begin
        n_state  = r_state;
        n_mret   = r_mret;
        n_op     = r_op;
        n_eq     = r_eq;
        n_exp    = r_exp;
        n_sv     = r_sv;
        n_sh     = r_sh;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_a      = r_a;
        n_b      = r_b;
        n_mx     = r_mx;
        n_my     = r_my;
        n_macc   = r_macc;
        n_ea     = r_ea;
        n_eb     = r_eb;
        n_u      = r_u;
        n_v      = r_v;
        n_acc    = r_acc;
        n_base   = r_base;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        n_ores   = r_ores;
        n_oeq    = r_oeq;

        if (r_ovalid && i_m_axis_tready)
            n_ovalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_op    = i_s_axis_tuser;
                    n_a     = i_s_axis_tdata[W-1:0];
                    n_b     = i_s_axis_tdata[2*W-1:W];
                    n_eq    = (i_s_axis_tdata[W-1:0] == i_s_axis_tdata[2*W-1:W]);
                    n_exp   = i_s_axis_tdata[2*W+62:2*W];
                    n_sv    = i_s_axis_tdata[2*W+126:2*W+63];
                    n_sh    = {i_s_axis_tdata[W-1:0], {(64-W){1'b0}}};
                    n_rem   = '0;
                    n_cnt   = 7'(W);
                    n_state = S_RED_A;
                end
            end
            S_RED_A: begin
                n_rem = red_q;
                n_sh  = {r_sh[62:0], 1'b0};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_a     = red_q;
                    n_sh    = {r_b, {(64-W){1'b0}}};
                    n_rem   = '0;
                    n_cnt   = 7'(W);
                    n_state = S_RED_B;
                end
            end
            S_RED_B: begin
                n_rem = red_q;
                n_sh  = {r_sh[62:0], 1'b0};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_b     = red_q;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (r_m < W'(2)) begin
                    n_res   = '0;
                    n_state = S_OUT;
                end else begin
                    case (r_op)
                        OP_ADD: begin
                            n_res   = add_m(r_a, r_b, r_m);
                            n_state = S_OUT;
                        end
                        OP_SUB: begin
                            n_res   = sub_m(r_a, r_b, r_m);
                            n_state = S_OUT;
                        end
                        OP_NEG: begin
                            n_res   = sub_m('0, r_a, r_m);
                            n_state = S_OUT;
                        end
                        OP_MUL: begin
                            n_mx    = r_a;
                            n_my    = r_b;
                            n_macc  = '0;
                            n_cnt   = 7'(W);
                            n_mret  = MR_OUT;
                            n_state = S_MUL;
                        end
                        OP_DIV: begin
                            n_ea    = r_b;
                            n_eb    = r_m;
                            n_u     = W'(1);
                            n_v     = '0;
                            n_state = S_EU_CHK;
                        end
                        OP_INV: begin
                            n_ea    = r_a;
                            n_eb    = r_m;
                            n_u     = W'(1);
                            n_v     = '0;
                            n_state = S_EU_CHK;
                        end
                        OP_POW: begin
                            n_acc   = W'(1);
                            n_base  = r_a;
                            n_state = S_PW_CHK;
                        end
                        default: begin
                            n_sh    = r_sv[63] ? (64'd0 - r_sv) : r_sv;
                            n_rem   = '0;
                            n_cnt   = 7'd64;
                            n_state = S_RED_SV;
                        end
                    endcase
                end
            end
            S_RED_SV: begin
                n_rem = red_q;
                n_sh  = {r_sh[62:0], 1'b0};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_res   = r_sv[63] ? sub_m('0, red_q, r_m) : red_q;
                    n_state = S_OUT;
                end
            end
            S_MUL: begin
                n_macc = mul_q;
                n_my   = {r_my[W-2:0], 1'b0};
                n_cnt  = r_cnt - 7'd1;
                if (r_cnt == 7'd1)
                    n_state = S_MUL_RET;
            end
            S_MUL_RET: begin
                case (r_mret)
                    MR_OUT: begin
                        n_res   = r_macc;
                        n_state = S_OUT;
                    end
                    MR_EU: begin
                        n_v     = sub_m(r_u, r_macc, r_m);
                        n_u     = r_v;
                        n_ea    = r_eb;
                        n_eb    = r_rem;
                        n_state = S_EU_CHK;
                    end
                    MR_PACC: begin
                        n_acc   = r_macc;
                        n_mx    = r_base;
                        n_my    = r_base;
                        n_macc  = '0;
                        n_cnt   = 7'(W);
                        n_mret  = MR_PBASE;
                        n_state = S_MUL;
                    end
                    default: begin
                        n_base  = r_macc;
                        n_exp   = {1'b0, r_exp[62:1]};
                        n_state = S_PW_CHK;
                    end
                endcase
            end
            S_EU_CHK: begin
                if (r_eb == '0) begin
                    if (r_op == OP_DIV) begin
                        n_mx    = r_a;
                        n_my    = r_u;
                        n_macc  = '0;
                        n_cnt   = 7'(W);
                        n_mret  = MR_OUT;
                        n_state = S_MUL;
                    end else begin
                        n_res   = r_u;
                        n_state = S_OUT;
                    end
                end else begin
                    n_rem   = '0;
                    n_cnt   = 7'(W);
                    n_state = S_EU_DIV;
                end
            end
            S_EU_DIV: begin
                n_rem = div_r[W-1:0];
                n_ea  = div_q;
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_mx    = r_v;
                    n_my    = div_q;
                    n_macc  = '0;
                    n_cnt   = 7'(W);
                    n_mret  = MR_EU;
                    n_state = S_MUL;
                end
            end
            S_PW_CHK: begin
                if (r_exp == '0) begin
                    n_res   = r_acc;
                    n_state = S_OUT;
                end else if (r_exp[0]) begin
                    n_mx    = r_acc;
                    n_my    = r_base;
                    n_macc  = '0;
                    n_cnt   = 7'(W);
                    n_mret  = MR_PACC;
                    n_state = S_MUL;
                end else begin
                    n_mx    = r_base;
                    n_my    = r_base;
                    n_macc  = '0;
                    n_cnt   = 7'(W);
                    n_mret  = MR_PBASE;
                    n_state = S_MUL;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_ores   = r_res;
                    n_oeq    = r_eq;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASSERT_CLK(a_accept_leaves_idle, i_clk, i_rst_n, s_accept |=> !o_s_axis_tready, "accept did not start work")
    `ASSERT_CLK(a_out_loads, i_clk, i_rst_n, (r_state == S_OUT && (!r_ovalid || i_m_axis_tready)) |=> (r_ovalid && r_state == S_IDLE), "result not loaded")
    `ASSERT_CLK(a_div_nonzero, i_clk, i_rst_n, (r_state == S_EU_DIV) |-> (r_eb != '0), "Euclid divisor is zero")

endmodule

/* tb/tb_modular_arithmetic_unit.sv */
// Testbench for the modular arithmetic unit: directed and random operations against a predictor.
`timescale 1ns / 100ps

module tb_modular_arithmetic_unit;
    import mau_pkg::*;

    localparam int W = 31;
    localparam int TDW = ((2*W+127+7)/8)*8;
    localparam int RDW = ((W+7)/8)*8;
    localparam longint LIMIT = 4000000;

    typedef struct packed {
        logic [W-1:0] value;
        logic         eq;
    } t_answer;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_wr_en = 1'b0;
    logic [W-1:0]    i_cfg_wr_data = '0;
    logic            i_s_axis_tvalid = 1'b0;
    logic            o_s_axis_tready;
    logic [TDW-1:0]  i_s_axis_tdata = '0;
    logic [2:0]      i_s_axis_tuser = '0;
    logic            o_m_axis_tvalid;
    logic            i_m_axis_tready = 1'b0;
    logic [RDW-1:0]  o_m_axis_tdata;
    logic [0:0]      o_m_axis_tuser;

    modular_arithmetic_unit #(.VALUE_WIDTH(W)) dut (.*);

    always #1 i_clk = ~i_clk;

    t_answer        answers_due[$];
    logic [63:0]    field_mod;
    int             errors = 0;
    int             n_sent = 0;
    int             n_got = 0;
    longint         cycle = 0;
    bit             calm = 1'b0;
    int             op_hits[8];

    // ---------------- predictor ----------------
    function automatic logic [63:0] m_add(logic [63:0] a, b, m);
        logic [63:0] s;
        s = a + b;
        return (s >= m) ? s - m : s;
    endfunction

    function automatic logic [63:0] m_sub(logic [63:0] a, b, m);
        return (a >= b) ? a - b : a + (m - b);
    endfunction

    function automatic logic [63:0] m_mul(logic [63:0] a, b, m);
        logic [127:0] p;
        p = a * b;
        return p % m;
    endfunction

    function automatic logic [63:0] m_inv(logic [63:0] x, m);
        logic [63:0] a, b, u, v, q, r, nu;
        a = x; b = m; u = 1 % m; v = 0;
        while (b > 0) begin
            q = a / b;
            r = a - q * b;
            a = b;
            b = r;
            nu = m_sub(u, m_mul(q % m, v, m), m);
            u = v;
            v = nu;
        end
        return u;
    endfunction

    function automatic logic [63:0] m_pow(logic [63:0] x, logic [62:0] n, logic [63:0] m);
        logic [63:0] acc, base;
        acc = 1 % m; base = x;
        while (n > 0) begin
            if (n[0]) acc = m_mul(acc, base, m);
            base = m_mul(base, base, m);
            n = n >> 1;
        end
        return acc;
    endfunction

    function automatic t_answer field_op(logic [2:0] op, logic [W-1:0] ra, rb,
                                         logic [62:0] e, logic [63:0] sv);
        t_answer ans;
        logic [63:0] m, a, b, r;
        m = field_mod; r = 0;
        if (m >= 2) begin
            a = ra % m; b = rb % m;
            case (op)
                OP_ADD: r = m_add(a, b, m);
                OP_SUB: r = m_sub(a, b, m);
                OP_MUL: r = m_mul(a, b, m);
                OP_DIV: r = m_mul(a, m_inv(b, m), m);
                OP_INV: r = m_inv(a, m);
                OP_POW: r = m_pow(a, e, m);
                OP_NEG: r = m_sub(0, a, m);
                default: begin
                    if (sv[63]) r = m_sub(0, (64'd0 - sv) % m, m);
                    else r = sv % m;
                end
            endcase
        end
        ans.value = r[W-1:0];
        ans.eq = (ra == rb);
        return ans;
    endfunction

    // ---------------- drivers ----------------
    task automatic send_item(logic [2:0] op, logic [W-1:0] a, b, logic [62:0] e,
                             logic [63:0] sv);
        while (!calm && $urandom_range(99) < 36) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {{(TDW-2*W-127){1'b0}}, sv, e, b, a};
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        answers_due.push_back(field_op(op, a, b, e, sv));
        n_sent++;
        op_hits[op]++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_modulus(logic [W-1:0] m);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        field_mod = {33'd0, m};
    endtask

    function automatic logic [W-1:0] rand_below(logic [63:0] m);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return (m >= 2) ? W'(r % m) : W'(r);
    endfunction

    function automatic logic [62:0] rand_exp();
        logic [62:0] e;
        e = 63'({$urandom, $urandom});
        case ($urandom_range(3))
            0: e = e >> $urandom_range(62);
            1: e = e & 63'hFFFF;
            default: ;
        endcase
        return e;
    endfunction

    task automatic send_random(int n);
        logic [W-1:0] a, b;
        repeat (n) begin
            a = rand_below(field_mod);
            b = ($urandom_range(7) == 0) ? a : rand_below(field_mod);
            send_item(3'($urandom_range(7)), a, b, rand_exp(), {$urandom, $urandom});
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_directed_extremes();
        logic [W-1:0] mx;
        mx = W'(field_mod - 1);
        send_item(OP_ADD, mx, mx, 0, 0);
        send_item(OP_ADD, 0, 0, 0, 0);
        send_item(OP_SUB, 0, mx, 0, 0);
        send_item(OP_SUB, mx, 0, 0, 0);
        send_item(OP_MUL, mx, mx, 0, 0);
        send_item(OP_DIV, 5, 0, 0, 0);
        send_item(OP_DIV, mx, 3, 0, 0);
        send_item(OP_INV, 0, 1, 0, 0);
        send_item(OP_INV, 1, 0, 0, 0);
        send_item(OP_INV, mx, 2, 0, 0);
        send_item(OP_POW, 2, 0, 63'h0, 0);
        send_item(OP_POW, 0, 0, 63'h0, 0);
        send_item(OP_POW, mx, 1, {63{1'b1}}, 0);
        send_item(OP_POW, 3, 0, 63'h1, 0);
        send_item(OP_NEG, 0, 0, 0, 0);
        send_item(OP_NEG, mx, 7, 0, 0);
        send_item(OP_RED, 1, 1, 0, 64'h8000_0000_0000_0000);
        send_item(OP_RED, 2, 3, 0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(OP_RED, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        // operands not below modulus
        send_item(OP_ADD, {W{1'b1}}, {W{1'b1}}, 0, 0);
        send_item(OP_MUL, {W{1'b1}}, W'(field_mod), 0, 0);
    endtask

    task automatic test_small_moduli();
        set_modulus(12);   // not prime: non-coprime inverse
        send_item(OP_INV, 4, 0, 0, 0);
        send_item(OP_DIV, 7, 6, 0, 0);
        send_item(OP_POW, 11, 11, 63'd12345, 0);
        send_random(12);
        set_modulus(2);
        send_random(10);
        set_modulus(1);    // degenerate: all zero
        send_random(6);
        set_modulus(0);
        send_random(4);
    endtask

    task automatic test_wide_modulus();
        set_modulus({W{1'b1}});
        send_item(OP_MUL, W'({W{1'b1}} - 1), W'({W{1'b1}} - 1), 0, 0);
        send_item(OP_INV, W'({W{1'b1}} - 1), 0, 0, 0);
        send_random(40);
    endtask

    task automatic test_random_default();
        set_modulus(W'(MODULUS_RESET));
        send_random(90);
        calm = 1'b1;
        send_random(40);
        calm = 1'b0;
        set_modulus(W'($urandom_range(32'h7FFF_FFFF, 3)));
        send_random(50);
    endtask

    // ---------------- checker ----------------
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("tb_modular_arithmetic_unit: errors");
            $finish;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_got <= n_got + 1;
            if (answers_due.size() == 0) begin
                errors <= errors + 1;
                $display("%0t: unexpected transfer result %0d", $time, o_m_axis_tdata);
            end else begin
                t_answer want;
                want = answers_due.pop_front();
                if (o_m_axis_tdata != RDW'(want.value) || o_m_axis_tuser[0] != want.eq) begin
                    errors <= errors + 1;
                    $display("%0t: mismatch expected result %0d eq %0b, got %0d eq %0b",
                             $time, want.value, want.eq, o_m_axis_tdata, o_m_axis_tuser[0]);
                end
            end
        end
    end

    always @(negedge i_clk)
        i_m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 36);

    initial begin
        field_mod = MODULUS_RESET;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_extremes();
        test_small_moduli();
        test_wide_modulus();
        test_random_default();
        drain();
        $display("covered %0d transfers in, %0d out, over moduli 0,1,2,12,default,2^31-1,random",
                 n_sent, n_got);
        $display("ops add %0d sub %0d mul %0d div %0d inv %0d pow %0d neg %0d red %0d",
                 op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4], op_hits[5],
                 op_hits[6], op_hits[7]);
        if (errors == 0 && answers_due.size() == 0)
            $display("tb_modular_arithmetic_unit: clean");
        else
            $display("tb_modular_arithmetic_unit: errors");
        $finish;
    end

endmodule
